/* sv/bfpa_pkg.sv */
// Shared types and constants of the best-fit partition allocator.
// Holds field widths, operation and status codes, and controller/datapath structs.
// Depends on nothing.
`default_nettype none

package bfpa_pkg;

    localparam int OP_W      = 2;
    localparam int PID_W     = 8;
    localparam int IDX_W     = 4;
    localparam int AMT_W     = 16;
    localparam int ST_W      = 2;
    localparam int TOTAL_W   = 20;
    localparam int CFG_W     = 5;

    localparam int MAX_SLOTS_DEF = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOOWNER  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADINDEX = 2'd3;

    typedef struct packed {
        logic             taken;
        logic [PID_W-1:0] owner;
        logic [AMT_W-1:0] size;
        logic [AMT_W-1:0] frag;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic prep;
        logic scan;
        logic commit;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_sts;

endpackage

`default_nettype wire

/* sv/bfpa_in_if.sv */
// Request channel of the partition allocator: valid, ready and one request item.
// Depends on bfpa_pkg.
`default_nettype none

interface bfpa_in_if
    import bfpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [PID_W-1:0] process_id;
    logic [IDX_W-1:0] slot_index;
    logic [AMT_W-1:0] amount;

    modport source(output valid, operation, process_id, slot_index, amount, input ready);
    modport sink(input valid, operation, process_id, slot_index, amount, output ready);
endinterface

`default_nettype wire

/* sv/bfpa_out_if.sv */
// Result channel of the partition allocator: valid, ready and one result item.
// Depends on bfpa_pkg.
`default_nettype none

interface bfpa_out_if
    import bfpa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [IDX_W-1:0]   chosen_slot;
    logic [AMT_W-1:0]   internal_fragment;
    logic [TOTAL_W-1:0] free_total;
    logic [TOTAL_W-1:0] internal_total;

    modport source(output valid, status, chosen_slot, internal_fragment, free_total,
                   internal_total, input ready);
    modport sink(input valid, status, chosen_slot, internal_fragment, free_total,
                 internal_total, output ready);
endinterface

`default_nettype wire

/* sv/bfpa_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module bfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/bfpa_ctrl.sv */
// Controller of the partition allocator: sequences capture, scan, commit and result.
// Depends on bfpa_pkg.
`default_nettype none

module bfpa_ctrl
    import bfpa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PREP   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign finish      = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (finish) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* sv/bfpa_dp.sv */
// Datapath of the partition allocator: partition table, entry scan, totals and result.
// Depends on bfpa_pkg and bfpa_ram.
`default_nettype none

module bfpa_dp
    import bfpa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [PID_W-1:0]   i_process_id,
    input  wire logic [IDX_W-1:0]   i_slot_index,
    input  wire logic [AMT_W-1:0]   i_amount,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    output logic [ST_W-1:0]         o_status,
    output logic [IDX_W-1:0]        o_chosen_slot,
    output logic [AMT_W-1:0]        o_internal_fragment,
    output logic [TOTAL_W-1:0]      o_free_total,
    output logic [TOTAL_W-1:0]      o_internal_total
);

    localparam int AW     = $clog2(MAX_SLOTS);
    localparam int CW_RAW = $clog2(MAX_SLOTS + 1);
    localparam int CW     = (CW_RAW > CFG_W) ? CW_RAW : CFG_W;
    localparam int SW_RAW = $clog2(MAX_SLOTS * 65535 + 1);
    localparam int SW     = (SW_RAW > TOTAL_W) ? SW_RAW : TOTAL_W;
    localparam int EW     = $bits(t_entry);

    logic [CFG_W-1:0]     r_cfg;
    logic [OP_W-1:0]      r_op;
    logic [PID_W-1:0]     r_pid;
    logic [IDX_W-1:0]     r_idx;
    logic [AMT_W-1:0]     r_amt;
    logic [MAX_SLOTS-1:0] r_ent_valid;
    logic [CW-1:0]        r_cnt;
    logic                 r_pend;
    logic [CW-1:0]        r_rd_idx;
    logic                 r_rd_vld;
    logic [SW-1:0]        r_free;
    logic [SW-1:0]        r_int;
    logic                 r_found;
    logic [CW-1:0]        r_best;
    logic [AMT_W-1:0]     r_best_size;
    logic [AMT_W-1:0]     r_frag;

    logic [ST_W-1:0]      r_o_status;
    logic [IDX_W-1:0]     r_o_chosen;
    logic [AMT_W-1:0]     r_o_frag;
    logic [TOTAL_W-1:0]   r_o_free;
    logic [TOTAL_W-1:0]   r_o_int;

    logic [CW-1:0]        cfg_ext;
    logic [CW-1:0]        n_active;
    logic [CW-1:0]        idx_ext;
    logic                 load_ok;
    logic                 issue;
    logic [EW-1:0]        rd_word;
    t_entry               ent;
    logic                 match;
    logic                 cand;
    logic [AMT_W-1:0]     frag_new;
    logic                 we;
    logic [AW-1:0]        waddr;
    t_entry               wdata;
    logic [ST_W-1:0]      n_o_status;
    logic [IDX_W-1:0]     n_o_chosen;
    logic [AMT_W-1:0]     n_o_frag;

    assign cfg_ext  = CW'(r_cfg);
    assign n_active = (cfg_ext < CW'(MAX_SLOTS)) ? cfg_ext : CW'(MAX_SLOTS);
    assign idx_ext  = CW'(r_idx);
    assign load_ok  = (idx_ext < n_active);
    assign issue    = i_cmd.scan && (r_cnt < n_active);

    assign o_sts.scan_done = (r_cnt == n_active) && !r_pend;

    bfpa_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_SLOTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_cnt[AW-1:0]),
        .o_rdata(rd_word)
    );

    assign ent      = r_rd_vld ? t_entry'(rd_word) : t_entry'('0);
    assign match    = (r_op == OP_RELEASE) && ent.taken && (ent.owner == r_pid);
    assign cand     = (r_op == OP_ALLOC) && !ent.taken && (r_amt <= ent.size) &&
                      (!r_found || (ent.size < r_best_size));
    assign frag_new = r_best_size - r_amt;

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        priority if (i_cmd.prep && (r_op == OP_LOAD) && load_ok) begin
            we         = 1'b1;
            waddr      = idx_ext[AW-1:0];
            wdata.size = r_amt;
        end else if (i_cmd.scan && r_pend && match) begin
            we          = 1'b1;
            waddr       = r_rd_idx[AW-1:0];
            wdata.owner = ent.owner;
            wdata.size  = ent.size;
        end else if (i_cmd.commit && (r_op == OP_ALLOC) && r_found) begin
            we          = 1'b1;
            waddr       = r_best[AW-1:0];
            wdata.taken = 1'b1;
            wdata.owner = r_pid;
            wdata.size  = r_best_size;
            wdata.frag  = frag_new;
        end else begin
            we = 1'b0;
        end
    end

    always_comb begin
        n_o_status = ST_OK;
        n_o_chosen = '0;
        n_o_frag   = '0;
        unique case (r_op)
            OP_LOAD: begin
                if (load_ok) begin
                    n_o_chosen = r_idx;
                end else begin
                    n_o_status = ST_BADINDEX;
                end
            end
            OP_ALLOC: begin
                if (r_found) begin
                    n_o_chosen = r_best[IDX_W-1:0];
                    n_o_frag   = r_frag;
                end else begin
                    n_o_status = ST_NOFIT;
                end
            end
            OP_RELEASE: begin
                if (r_found) begin
                    n_o_chosen = r_best[IDX_W-1:0];
                end else begin
                    n_o_status = ST_NOOWNER;
                end
            end
            default: begin
                n_o_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_ent_valid <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (we) begin
                r_ent_valid[waddr] <= 1'b1;
            end
            if (i_cmd.prep) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= issue;
                if (issue) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_pid <= i_process_id;
            r_idx <= i_slot_index;
            r_amt <= i_amount;
        end
        if (issue) begin
            r_rd_idx <= r_cnt;
            r_rd_vld <= r_ent_valid[r_cnt[AW-1:0]];
        end
        if (i_cmd.prep) begin
            r_free      <= '0;
            r_int       <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_best_size <= '0;
            r_frag      <= '0;
        end else if (i_cmd.scan && r_pend) begin
            if (ent.taken && !match) begin
                r_int <= r_int + SW'(ent.frag);
            end else begin
                r_free <= r_free + SW'(ent.size);
            end
            if (cand) begin
                r_found     <= 1'b1;
                r_best      <= r_rd_idx;
                r_best_size <= ent.size;
            end else if (match && !r_found) begin
                r_found <= 1'b1;
                r_best  <= r_rd_idx;
            end
        end else if (i_cmd.commit && (r_op == OP_ALLOC) && r_found) begin
            r_free <= r_free - SW'(r_best_size);
            r_int  <= r_int + SW'(frag_new);
            r_frag <= frag_new;
        end
        if (i_cmd.finish) begin
            r_o_status <= n_o_status;
            r_o_chosen <= n_o_chosen;
            r_o_frag   <= n_o_frag;
            r_o_free   <= (r_free > SW'(TOTAL_MAX)) ? TOTAL_MAX : r_free[TOTAL_W-1:0];
            r_o_int    <= (r_int > SW'(TOTAL_MAX)) ? TOTAL_MAX : r_int[TOTAL_W-1:0];
        end
    end

    assign o_status            = r_o_status;
    assign o_chosen_slot       = r_o_chosen;
    assign o_internal_fragment = r_o_frag;
    assign o_free_total        = r_o_free;
    assign o_internal_total    = r_o_int;

endmodule

`default_nettype wire

/* sv/best_fit_partition_allocator.sv */
// Top level of the best-fit fixed-partition allocator.
// Depends on bfpa_pkg, bfpa_in_if, bfpa_out_if, bfpa_ctrl and bfpa_dp.
//
// Each request item on i_req loads a partition size, allocates the smallest
// free partition that fits, or releases every partition of a process. Each
// request gives exactly one result item on o_rsp with the status, the chosen
// partition, the granted fragment and the free and fragment totals.
// The register partitions_in_use is written through i_cfg_we and i_cfg_wdata;
// the user must write it only while no request is in flight, and the block
// itself does not enforce this. It sets how many entries are searched. A
// request walks the active entries one per cycle through the read port of
// the partition table. One request is handled at a time; i_req.ready is high
// only when the block is idle, so a new request is not taken before the last
// one has placed its result in the output register. The result waits there,
// so a new request can be accepted while the receiver stalls; that request
// then holds before its result until the register is free.
// Reset empties the partition table, sets partitions_in_use to 16 and clears
// any pending result.
`default_nettype none

module best_fit_partition_allocator
    import bfpa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    bfpa_in_if.sink               i_req,
    bfpa_out_if.source            o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bfpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_out_ready(o_rsp.ready),
        .o_out_valid(o_rsp.valid),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bfpa_dp #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_operation        (i_req.operation),
        .i_process_id       (i_req.process_id),
        .i_slot_index       (i_req.slot_index),
        .i_amount           (i_req.amount),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_status           (o_rsp.status),
        .o_chosen_slot      (o_rsp.chosen_slot),
        .o_internal_fragment(o_rsp.internal_fragment),
        .o_free_total       (o_rsp.free_total),
        .o_internal_total   (o_rsp.internal_total)
    );

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready
    ) else $error("Request accepted while another was in flight.");

    a_finish_shows_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_rsp.valid
    ) else $error("Finished item did not appear on the result channel.");

    a_failed_result_clean: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_NOFIT || o_rsp.status == ST_NOOWNER ||
                         o_rsp.status == ST_BADINDEX))
        |-> (o_rsp.chosen_slot == '0 && o_rsp.internal_fragment == '0)
    ) else $error("Failed item carries a partition or fragment.");

endmodule

`default_nettype wire

/* tb/best_fit_partition_allocator_tb.sv */
// Self-checking testbench of the best-fit partition allocator: random and directed requests
// are checked against a predictor of the partition table under random stalls on both channels.
// Depends on bfpa_pkg, bfpa_in_if, bfpa_out_if and best_fit_partition_allocator.
module best_fit_partition_allocator_tb;
    import bfpa_pkg::*;

    localparam int N_SLOTS = MAX_SLOTS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_ITEMS = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 80;
    localparam int END_CYCLES = 40;
    localparam int PRINT_LIMIT = 100;
    localparam int TIMEOUT_UNITS = 2000000;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [PID_W-1:0] pid;
        logic [IDX_W-1:0] slot;
        logic [AMT_W-1:0] amount;
    } t_request;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [IDX_W-1:0]   slot;
        logic [AMT_W-1:0]   frag;
        logic [TOTAL_W-1:0] free_total;
        logic [TOTAL_W-1:0] internal_total;
    } t_outcome;

    typedef enum {PEND_ITEM, PEND_CFG, PEND_DRAIN, PEND_HOLD} t_pend_kind;

    typedef struct {
        t_pend_kind       kind;
        logic [CFG_W-1:0] cfg;
        t_request         req;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    bfpa_in_if req_if();
    bfpa_out_if rsp_if();

    best_fit_partition_allocator #(.MAX_SLOTS(N_SLOTS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req(req_if),
        .o_rsp(rsp_if)
    );

    // Predicted partition table and register.
    logic [AMT_W-1:0] part_size [N_SLOTS];
    bit               part_taken [N_SLOTS];
    logic [PID_W-1:0] part_owner [N_SLOTS];
    logic [AMT_W-1:0] part_frag [N_SLOTS];
    logic [CFG_W-1:0] slots_in_use = CFG_RESET;

    t_pending pending_items[$];
    t_outcome expected_results[$];
    t_request cur_req = '0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int holds_done = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned sat_total(int unsigned acc, int unsigned add);
        return (acc + add > 32'(TOTAL_MAX)) ? 32'(TOTAL_MAX) : acc + add;
    endfunction

    function automatic t_outcome allocate_step(t_request r);
        t_outcome res;
        int n;
        int best;
        bit found;
        int unsigned free_sum;
        int unsigned frag_sum;
        n = (int'(slots_in_use) < N_SLOTS) ? int'(slots_in_use) : N_SLOTS;
        res = '0;
        found = 1'b0;
        best = 0;
        free_sum = 0;
        frag_sum = 0;
        case (r.op)
            OP_LOAD: begin
                if (int'(r.slot) < n) begin
                    part_size[r.slot] = r.amount;
                    part_taken[r.slot] = 1'b0;
                    part_owner[r.slot] = '0;
                    part_frag[r.slot] = '0;
                    res.slot = r.slot;
                end else begin
                    res.status = ST_BADINDEX;
                end
            end
            OP_ALLOC: begin
                for (int i = 0; i < n; i++) begin
                    if (!part_taken[i] && r.amount <= part_size[i] &&
                        (!found || part_size[i] < part_size[best])) begin
                        best = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    part_taken[best] = 1'b1;
                    part_owner[best] = r.pid;
                    part_frag[best] = part_size[best] - r.amount;
                    res.slot = IDX_W'(best);
                    res.frag = part_frag[best];
                end else begin
                    res.status = ST_NOFIT;
                end
            end
            OP_RELEASE: begin
                for (int i = 0; i < n; i++) begin
                    if (part_taken[i] && part_owner[i] == r.pid) begin
                        if (!found) begin
                            res.slot = IDX_W'(i);
                        end
                        found = 1'b1;
                        part_taken[i] = 1'b0;
                        part_frag[i] = '0;
                    end
                end
                if (!found) begin
                    res.status = ST_NOOWNER;
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < n; i++) begin
            if (part_taken[i]) begin
                frag_sum = sat_total(frag_sum, 32'(part_frag[i]));
            end else begin
                free_sum = sat_total(free_sum, 32'(part_size[i]));
            end
        end
        res.free_total = TOTAL_W'(free_sum);
        res.internal_total = TOTAL_W'(frag_sum);
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic push_item(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                             logic [IDX_W-1:0] slot, logic [AMT_W-1:0] amount);
        t_pending p;
        p.kind = PEND_ITEM;
        p.cfg = '0;
        p.req = '{op: op, pid: pid, slot: slot, amount: amount};
        pending_items.push_back(p);
    endtask

    task automatic push_marker(t_pend_kind kind, logic [CFG_W-1:0] cfg);
        t_pending p;
        p.kind = kind;
        p.cfg = cfg;
        p.req = '0;
        pending_items.push_back(p);
    endtask

    function automatic logic [AMT_W-1:0] draw_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick == 2) return AMT_W'($urandom_range(0, 65535));
        return AMT_W'($urandom_range(1, 1000));
    endfunction

    // Request driver.
    always @(posedge i_clk) begin : drive_proc
        t_pending nxt;
        logic offer;
        logic cfg_write;
        offer = req_if.valid;
        cfg_write = 1'b0;
        if (!i_rst_n) begin
            offer = 1'b0;
            quiet_cycles = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(allocate_step(cur_req));
                offer = 1'b0;
            end
            if (expected_results.size() == 0 && !offer) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items[0];
                    case (nxt.kind)
                        PEND_ITEM: begin
                            if (pending_items.size() > TAIL_ITEMS &&
                                $urandom_range(0, 4) == 0) begin
                                send_gap = $urandom_range(0, 3);
                            end else begin
                                cur_req = nxt.req;
                                offer = 1'b1;
                                void'(pending_items.pop_front());
                            end
                        end
                        PEND_CFG: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                cfg_write = 1'b1;
                                i_cfg_wdata <= nxt.cfg;
                                slots_in_use = nxt.cfg;
                                void'(pending_items.pop_front());
                            end
                        end
                        PEND_DRAIN: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                void'(pending_items.pop_front());
                            end
                        end
                        default: begin
                            hold_requests++;
                            void'(pending_items.pop_front());
                        end
                    endcase
                end
            end
        end
        i_cfg_we <= cfg_write;
        req_if.valid <= offer;
        req_if.operation <= cur_req.op;
        req_if.process_id <= cur_req.pid;
        req_if.slot_index <= cur_req.slot;
        req_if.amount <= cur_req.amount;
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin : collect_proc
        t_outcome got;
        t_outcome want;
        logic take;
        take = 1'b0;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{status: rsp_if.status, slot: rsp_if.chosen_slot,
                        frag: rsp_if.internal_fragment, free_total: rsp_if.free_total,
                        internal_total: rsp_if.internal_total};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result item, status", 32'(got.status), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.slot !== want.slot)
                        report_mismatch("chosen_slot", 32'(got.slot), 32'(want.slot));
                    if (got.frag !== want.frag)
                        report_mismatch("internal_fragment", 32'(got.frag), 32'(want.frag));
                    if (got.free_total !== want.free_total)
                        report_mismatch("free_total", 32'(got.free_total),
                                        32'(want.free_total));
                    if (got.internal_total !== want.internal_total)
                        report_mismatch("internal_total", 32'(got.internal_total),
                                        32'(want.internal_total));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left = HOLD_CYCLES - 1;
            end else if (recv_gap > 0) begin
                recv_gap--;
            end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                recv_gap = $urandom_range(0, 3);
            end else begin
                take = 1'b1;
            end
        end
        rsp_if.ready <= take;
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : main_proc
        int phase;
        int ops;
        int pick;
        int counted;
        logic [CFG_W-1:0] cfg_val;
        logic [PID_W-1:0] pool [5];
        logic [PID_W-1:0] rnd_pid;
        logic [IDX_W-1:0] rnd_slot;
        logic [AMT_W-1:0] rnd_amt;
        logic [AMT_W-1:0] alloc_amt;

        req_if.valid = 1'b0;
        req_if.operation = '0;
        req_if.process_id = '0;
        req_if.slot_index = '0;
        req_if.amount = '0;
        rsp_if.ready = 1'b0;
        for (int i = 0; i < N_SLOTS; i++) begin
            part_size[i] = '0;
            part_taken[i] = 1'b0;
            part_owner[i] = '0;
            part_frag[i] = '0;
        end

        // Directed part: empty table, ties, repeat grants, multi-slot release,
        // reload of a taken entry, hidden entries and zero entries in use.
        push_item(OP_UNUSED, 8'hFF, 4'hF, 16'hFFFF);
        push_item(OP_RELEASE, 8'd5, 4'd0, 16'd0);
        push_item(OP_ALLOC, 8'd1, 4'd0, 16'd0);
        push_item(OP_ALLOC, 8'd1, 4'd0, 16'd1);
        push_item(OP_LOAD, 8'd0, 4'd0, 16'd100);
        push_item(OP_LOAD, 8'd0, 4'd1, 16'd100);
        push_item(OP_LOAD, 8'd0, 4'd2, 16'd50);
        push_item(OP_LOAD, 8'd0, 4'd3, 16'hFFFF);
        push_item(OP_LOAD, 8'd0, 4'hF, 16'hFFFF);
        push_item(OP_ALLOC, 8'd7, 4'd0, 16'd60);
        push_item(OP_ALLOC, 8'd7, 4'd0, 16'd60);
        push_item(OP_ALLOC, 8'd9, 4'd0, 16'hFFFF);
        push_item(OP_ALLOC, 8'hAA, 4'd0, 16'hFFFF);
        push_item(OP_ALLOC, 8'hAB, 4'd0, 16'hFFFF);
        push_item(OP_RELEASE, 8'd7, 4'd0, 16'd0);
        push_item(OP_LOAD, 8'd0, 4'd3, 16'd1);
        push_item(OP_RELEASE, 8'd9, 4'd0, 16'd0);
        push_marker(PEND_CFG, 5'd3);
        push_item(OP_LOAD, 8'd0, 4'd5, 16'd10);
        push_item(OP_RELEASE, 8'hAA, 4'd0, 16'd0);
        push_item(OP_ALLOC, 8'd0, 4'd0, 16'd40);
        push_marker(PEND_CFG, 5'd0);
        push_item(OP_ALLOC, 8'd0, 4'd0, 16'd0);
        push_item(OP_RELEASE, 8'd0, 4'd0, 16'd0);
        push_item(OP_LOAD, 8'd0, 4'd0, 16'd0);
        push_marker(PEND_CFG, 5'd16);
        push_item(OP_RELEASE, 8'd0, 4'd0, 16'd0);

        // Random phases: a register setting, a full table load, then a mix of
        // grants and releases from a small set of processes with some noise.
        counted = 0;
        phase = 0;
        while (counted < RANDOM_ITEMS) begin
            case (phase)
                0: cfg_val = 5'd1;
                1: cfg_val = 5'd31;
                2: cfg_val = 5'd0;
                3: cfg_val = 5'd16;
                4: cfg_val = 5'd17;
                5: cfg_val = 5'd8;
                6: cfg_val = 5'd2;
                7: cfg_val = 5'd15;
                default: cfg_val = CFG_W'(($urandom_range(0, 3) == 0)
                                          ? $urandom_range(0, 31)
                                          : $urandom_range(1, 16));
            endcase
            push_marker(PEND_CFG, cfg_val);
            for (int i = 0; i < 5; i++) begin
                pool[i] = PID_W'($urandom_range(0, 255));
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                push_item(OP_LOAD, PID_W'($urandom_range(0, 255)), IDX_W'(i), draw_size());
                counted++;
            end
            if (phase == 3) begin
                push_marker(PEND_HOLD, '0);
            end
            ops = (cfg_val == 0) ? 8 : $urandom_range(40, 80);
            for (int k = 0; k < ops; k++) begin
                if (phase == 5 && k == ops / 2) begin
                    push_marker(PEND_DRAIN, '0);
                end
                pick = $urandom_range(0, 99);
                rnd_pid = PID_W'($urandom_range(0, 255));
                rnd_slot = IDX_W'($urandom_range(0, 15));
                rnd_amt = AMT_W'($urandom_range(0, 65535));
                if (pick < 50) begin
                    alloc_amt = ($urandom_range(0, 9) == 0) ? rnd_amt
                                                            : AMT_W'($urandom_range(0, 1100));
                    push_item(OP_ALLOC, pool[$urandom_range(0, 4)], rnd_slot, alloc_amt);
                    counted++;
                end else if (pick < 78) begin
                    push_item(OP_RELEASE,
                              ($urandom_range(0, 9) == 0) ? rnd_pid : pool[$urandom_range(0, 4)],
                              rnd_slot, rnd_amt);
                    counted++;
                end else if (pick < 90) begin
                    push_item(OP_LOAD, rnd_pid, rnd_slot, draw_size());
                    counted++;
                end else if (pick < 95) begin
                    push_item(OP_UNUSED, rnd_pid, rnd_slot, rnd_amt);
                end else begin
                    push_item(OP_ALLOC, rnd_pid, rnd_slot, rnd_amt);
                    counted++;
                end
            end
            phase++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_results.size() != 0 || req_if.valid)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch("results never delivered", expected_results.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
